>>> rtl/core/ufr_pkg.sv
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int unsigned TAG_LEN = 6;

  localparam logic [7:0] NEWLINE    = 8'h0a;
  localparam logic [7:0] CNT_MAX    = 8'd255;
  localparam logic [7:0] THR_RESET  = 8'd5;
  localparam logic       REQ_BYTE   = 1'b0;
  localparam logic       REQ_TICK   = 1'b1;
  localparam logic       REG_IDLE_THR = 1'b0;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_FRAMING = 2'd1,
    KIND_OVERRUN = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    SRC_ERR = 3'd0,
    SRC_OVR = 3'd1,
    SRC_TAG = 3'd2,
    SRC_BUF = 3'd3,
    SRC_NL  = 3'd4
  } src_e;

  typedef struct packed {
    logic emit;
    src_e src;
    logic last;
    logic idx_clr;
    logic idx_inc;
    logic fill_clr;
    logic store;
    logic chunk_set;
    logic chunk_clr;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic err;
    logic ready;
    logic hit;
    logic full;
    logic fill_nz;
    logic chunk;
    logic tag_end;
    logic buf_end;
    logic slot_free;
  } sts_t;

  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h55;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h52;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h30;
      3'd5:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/ufr_ctrl.sv
`timescale 1ns / 1ps

module ufr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ufr_pkg::sts_t sts_i,
  output ufr_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EVAL  = 8'b0000_0010,
    ST_ERR   = 8'b0000_0100,
    ST_TAG   = 8'b0000_1000,
    ST_BUF   = 8'b0001_0000,
    ST_NL    = 8'b0010_0000,
    ST_OVR   = 8'b0100_0000,
    ST_STORE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   nl_q, nl_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    nl_d    = nl_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        nl_d = sts_i.req_tick & ~sts_i.chunk;
        if (!sts_i.req_tick) begin
          if (sts_i.err) state_d = ST_ERR;
          else if (sts_i.full) state_d = sts_i.chunk ? ST_BUF : ST_TAG;
          else state_d = ST_STORE;
        end else if (!sts_i.hit) begin
          state_d = ST_IDLE;
        end else if (!sts_i.ready) begin
          state_d = ST_OVR;
        end else if (!sts_i.fill_nz) begin
          state_d = ST_IDLE;
        end else begin
          state_d = sts_i.chunk ? ST_BUF : ST_TAG;
        end
      end
      ST_ERR: begin
        cmd_o.emit = sts_i.slot_free;
        cmd_o.src  = ufr_pkg::SRC_ERR;
        cmd_o.last = ~sts_i.full;
        if (sts_i.slot_free) begin
          if (sts_i.full) state_d = sts_i.chunk ? ST_BUF : ST_TAG;
          else state_d = ST_STORE;
        end
      end
      ST_TAG: begin
        cmd_o.emit = sts_i.slot_free;
        cmd_o.src  = ufr_pkg::SRC_TAG;
        if (sts_i.slot_free) begin
          if (sts_i.tag_end) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_BUF;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_BUF: begin
        cmd_o.emit = sts_i.slot_free;
        cmd_o.src  = ufr_pkg::SRC_BUF;
        cmd_o.last = sts_i.buf_end & ~nl_q;
        if (sts_i.slot_free) begin
          if (sts_i.buf_end) begin
            cmd_o.idx_clr   = 1'b1;
            cmd_o.fill_clr  = 1'b1;
            cmd_o.chunk_set = ~sts_i.req_tick;
            cmd_o.chunk_clr = sts_i.req_tick & ~nl_q;
            if (!sts_i.req_tick) state_d = ST_STORE;
            else if (nl_q) state_d = ST_NL;
            else state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_NL: begin
        cmd_o.emit = sts_i.slot_free;
        cmd_o.src  = ufr_pkg::SRC_NL;
        cmd_o.last = 1'b1;
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      ST_OVR: begin
        cmd_o.emit = sts_i.slot_free;
        cmd_o.src  = ufr_pkg::SRC_OVR;
        cmd_o.last = 1'b1;
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      nl_q    <= nl_d;
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_buf_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUF) |-> sts_i.fill_nz)
    else $error("buffer walk with empty buffer");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> !sts_i.full)
    else $error("store into full buffer");

  a_tag_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAG) |-> !sts_i.chunk)
    else $error("tag sent while chunk open");
`endif

endmodule

>>> rtl/core/ufr_dp.sv
`timescale 1ns / 1ps

module ufr_dp #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [0:0]    in_user_i,
  input  logic [15:0]   in_data_i,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  input  ufr_pkg::cmd_t cmd_i,
  output ufr_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_data_o,
  output logic [1:0]    out_user_o,
  output logic          out_last_o
);

  localparam int unsigned FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned IDX_W  = (FILL_W > 3) ? FILL_W : 3;
  localparam int unsigned AW     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [7:0]        thr_q;
  logic [7:0]        idle_q;
  logic [7:0]        idle_inc;
  logic              idle_hit;
  logic              hit_q;
  logic              req_q, err_q, rdy_q;
  logic [7:0]        byte_q;
  logic [FILL_W-1:0] fill_q;
  logic              chunk_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        mem_q [BUF_DEPTH];
  logic [7:0]        rd_data_q;
  logic              out_valid_q;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [1:0]        out_kind_q, out_kind_d;
  logic              out_last_q;
  logic              cfg_wr;
  logic              slot_free;

  assign cfg_wr = psel & penable & pwrite & (paddr[2] == ufr_pkg::REG_IDLE_THR);
  assign prdata = (paddr[2] == ufr_pkg::REG_IDLE_THR) ? {24'd0, thr_q} : 32'd0;

  assign idle_inc = (idle_q == ufr_pkg::CNT_MAX) ? idle_q : idle_q + 8'd1;
  assign idle_hit = (idle_inc >= thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ufr_pkg::THR_RESET;
      idle_q <= 8'd0;
    end else begin
      if (cfg_wr) thr_q <= pwdata[7:0];
      if (accept_i) begin
        if (in_user_i[0] == ufr_pkg::REQ_BYTE) idle_q <= 8'd1;
        else idle_q <= idle_hit ? 8'd1 : idle_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q  <= in_user_i[0];
      byte_q <= in_data_i[7:0];
      err_q  <= in_data_i[8];
      rdy_q  <= in_data_i[9];
      hit_q  <= (in_user_i[0] == ufr_pkg::REQ_TICK) & idle_hit;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_q + IDX_W'(1);
  end

  assign rd_addr = (idx_d < IDX_W'(BUF_DEPTH)) ? idx_d[AW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fill_q  <= '0;
      chunk_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.fill_clr) fill_q <= '0;
      else if (cmd_i.store) fill_q <= fill_q + FILL_W'(1);
      if (cmd_i.chunk_set) chunk_q <= 1'b1;
      else if (cmd_i.chunk_clr) chunk_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem_q[fill_q[AW-1:0]] <= byte_q;
    rd_data_q <= mem_q[rd_addr];
  end

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    out_kind_d = ufr_pkg::KIND_DATA;
    out_byte_d = 8'd0;
    case (cmd_i.src)
      ufr_pkg::SRC_ERR: out_kind_d = ufr_pkg::KIND_FRAMING;
      ufr_pkg::SRC_OVR: out_kind_d = ufr_pkg::KIND_OVERRUN;
      ufr_pkg::SRC_TAG: out_byte_d = ufr_pkg::tag_byte(idx_q[2:0]);
      ufr_pkg::SRC_BUF: out_byte_d = rd_data_q;
      ufr_pkg::SRC_NL:  out_byte_d = ufr_pkg::NEWLINE;
      default:          out_byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= out_kind_d;
      out_byte_q <= out_byte_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_byte_q;
  assign out_user_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o.req_tick  = (req_q == ufr_pkg::REQ_TICK);
    sts_o.err       = err_q;
    sts_o.ready     = rdy_q;
    sts_o.hit       = hit_q;
    sts_o.full      = (fill_q == FILL_W'(BUF_DEPTH));
    sts_o.fill_nz   = (fill_q != '0);
    sts_o.chunk     = chunk_q;
    sts_o.tag_end   = (idx_q == IDX_W'(ufr_pkg::TAG_LEN - 1));
    sts_o.buf_end   = (idx_q == (IDX_W'(fill_q) - IDX_W'(1)));
    sts_o.slot_free = slot_free;
  end

endmodule

>>> rtl/core/uart_rx_idle_timeout_framer_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata: rx_byte, rx_error, host_ready; tuser: req_type
// m_axis   out  tvalid/tready          tdata: out_byte; tuser: out_kind; tlast: last
// apb      in   psel/penable, pready=1 idle_threshold at byte address 0
//
// A byte item without a flush passes evaluate and store; a tick with no result only evaluate.
// Each result is held in the output register until taken; the buffer walk reads one
// entry a cycle while the output register is free. Output stalls hold the controller in
// place; the next item is accepted while the last result still waits in the output
// register. Reset is asynchronous; the buffer memory is not cleared, only its fill count.

module uart_rx_idle_timeout_framer_core #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [8] rx_error, [9] host_ready
  input  logic [0:0]  s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ufr_pkg::cmd_t cmd;
  ufr_pkg::sts_t sts;
  logic          accept;

  assign pready = 1'b1;
  assign accept = s_axis_tvalid & s_axis_tready;

  ufr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  ufr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
